// ===== hdl/sies_pkg.sv =====
// Package with the shared types and codes of the safety interlock enable sequencer.
`timescale 1ns / 1ps

package sies_pkg;

    // User command codes. Codes above CMD_QUIT act as CMD_NONE.
    localparam logic [2:0] CMD_NONE    = 3'd0;
    localparam logic [2:0] CMD_ENABLE  = 3'd1;
    localparam logic [2:0] CMD_DISABLE = 3'd2;
    localparam logic [2:0] CMD_RETRY   = 3'd3;
    localparam logic [2:0] CMD_QUIT    = 3'd4;

    // Fault codes. Codes above FAULT_UNCLEAN_EXIT count as FAULT_UNCERTAIN.
    localparam logic [2:0] FAULT_NONE         = 3'd0;
    localparam logic [2:0] FAULT_HOLD_RELEASE = 3'd1;
    localparam logic [2:0] FAULT_PASSTHROUGH  = 3'd2;
    localparam logic [2:0] FAULT_UNCERTAIN    = 3'd3;
    localparam logic [2:0] FAULT_UNCLEAN_EXIT = 3'd4;

    typedef enum logic [1:0] {
        ST_DISABLED = 2'd0,
        ST_INACTIVE = 2'd1,
        ST_ACTIVE   = 2'd2,
        ST_LATCH    = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        RSN_NONE         = 4'd0,
        RSN_LATCH        = 4'd1,
        RSN_PERMISSION   = 4'd2,
        RSN_MULTIPLE     = 4'd3,
        RSN_DISCONNECTED = 4'd4,
        RSN_SESSION      = 4'd5,
        RSN_FOREGROUND   = 4'd6,
        RSN_VERIFYING    = 4'd7,
        RSN_RELEASE      = 4'd8
    } t_reason;

    // One input transaction: command, gate snapshot and observed fault.
    typedef struct packed {
        logic [2:0] command;
        logic       access_ok;
        logic       extra_ctrl;
        logic       ctrl_present;
        logic       session_available;
        logic       target_foreground;
        logic       filter_live;
        logic       controls_neutral;
        logic [2:0] observed_fault;
        logic       device_reports_latched;
        logic       cleanup_done;
        logic       recovery_check_ok;
    } t_item;

    // Persistent sequencer state.
    typedef struct packed {
        t_status    status;
        t_reason    reason;
        logic       enable;
        logic       latch;
        logic [2:0] fault;
        logic       disable_wait;
        logic       quit_pending;
    } t_state;

    // One result transaction.
    typedef struct packed {
        t_status    status;
        t_reason    reason;
        logic [2:0] fault_code;
        logic       fault_latched;
        logic       enabled;
        logic       drive_filter;
        logic       drive_dispatch;
        logic       drive_cleanup;
        logic       quit_clear;
    } t_result;

endpackage

// ===== hdl/sies_step.sv =====
// Next-state and result logic of the sequencer for one command transaction.
`timescale 1ns / 1ps

module sies_step (
    input  sies_pkg::t_item   i_item,
    input  sies_pkg::t_state  i_state,
    output sies_pkg::t_state  o_state,
    output sies_pkg::t_result o_result
);
    import sies_pkg::*;

    logic [2:0] cmd;
    logic [2:0] flt;
    logic [2:0] obs;
    logic       clean_ok;
    logic       retry;
    logic       lat_filter;
    logic       filter;
    logic       dispatch;
    logic       cleanup;
    logic       quit_ok;
    t_state     ns;

    // Drop to disabled: enable intent is kept as it is.
    function automatic t_state go_disabled(input t_state s);
        t_state r;
        r              = s;
        r.status       = ST_DISABLED;
        r.reason       = RSN_NONE;
        r.latch        = 1'b0;
        r.fault        = FAULT_NONE;
        r.disable_wait = 1'b0;
        r.quit_pending = 1'b0;
        return r;
    endfunction

    // Enter or hold the latch; a latch never shows an empty fault code.
    function automatic t_state go_latched(input t_state s, input logic [2:0] f);
        t_state r;
        r       = s;
        r.latch = 1'b1;
        if (f != FAULT_NONE) begin
            r.fault = f;
        end else if (r.fault == FAULT_NONE) begin
            r.fault = FAULT_UNCERTAIN;
        end
        r.status = ST_LATCH;
        r.reason = RSN_LATCH;
        return r;
    endfunction

    always_comb begin
        cmd = (i_item.command > CMD_QUIT) ? CMD_NONE : i_item.command;
        flt = (i_item.observed_fault > FAULT_UNCLEAN_EXIT) ? FAULT_UNCERTAIN
                                                           : i_item.observed_fault;
        if (flt != FAULT_NONE) begin
            obs = flt;
        end else if (i_item.device_reports_latched) begin
            obs = FAULT_UNCERTAIN;
        end else begin
            obs = FAULT_NONE;
        end
        clean_ok = i_item.cleanup_done && (obs == FAULT_NONE);
        retry    = (cmd == CMD_RETRY);

        ns       = i_state;
        filter   = 1'b0;
        dispatch = 1'b0;
        cleanup  = 1'b0;
        quit_ok  = 1'b0;

        if (cmd == CMD_ENABLE) begin
            ns.enable = 1'b1;
        end else if (cmd == CMD_QUIT) begin
            ns.quit_pending = 1'b1;
        end

        if (cmd == CMD_DISABLE) begin
            ns.enable       = 1'b0;
            ns.disable_wait = 1'b1;
            ns.quit_pending = 1'b0;
            cleanup         = 1'b1;
            ns = clean_ok ? go_disabled(ns) : go_latched(ns, obs);
        end else if (ns.disable_wait) begin
            if (retry) begin
                cleanup = 1'b1;
                ns = clean_ok ? go_disabled(ns) : go_latched(ns, obs);
            end else begin
                ns = go_latched(ns, FAULT_NONE);
            end
        end else if (ns.quit_pending) begin
            cleanup = 1'b1;
            if (clean_ok) begin
                quit_ok = 1'b1;
            end else begin
                ns = go_latched(ns, obs);
            end
        end else if (!ns.enable) begin
            ns = go_disabled(ns);
        end else begin
            if (obs != FAULT_NONE) begin
                if (!ns.latch || retry) begin
                    ns.fault = obs;
                end
                ns.latch = 1'b1;
            end else if (ns.latch && retry && clean_ok && i_item.access_ok &&
                         !i_item.extra_ctrl && i_item.ctrl_present &&
                         i_item.session_available && i_item.recovery_check_ok) begin
                ns.latch = 1'b0;
                ns.fault = FAULT_NONE;
            end

            if (ns.latch) begin
                cleanup = retry;
                ns      = go_latched(ns, FAULT_NONE);
            end else begin
                ns.fault = FAULT_NONE;
                priority if (!i_item.access_ok) begin
                    ns.reason = RSN_PERMISSION;
                end else if (i_item.extra_ctrl) begin
                    ns.reason = RSN_MULTIPLE;
                end else if (!i_item.ctrl_present) begin
                    ns.reason = RSN_DISCONNECTED;
                end else if (!i_item.session_available) begin
                    ns.reason = RSN_SESSION;
                end else if (!i_item.target_foreground) begin
                    ns.reason = RSN_FOREGROUND;
                end else if (!i_item.filter_live) begin
                    ns.reason = RSN_VERIFYING;
                end else if (!i_item.controls_neutral) begin
                    ns.reason = RSN_RELEASE;
                end else begin
                    ns.reason = RSN_NONE;
                end
                if (ns.reason == RSN_NONE) begin
                    ns.status = ST_ACTIVE;
                    filter    = 1'b1;
                    dispatch  = 1'b1;
                end else begin
                    ns.status = ST_INACTIVE;
                    filter    = i_item.ctrl_present && !i_item.extra_ctrl;
                end
            end
        end

        // Whenever this transaction leaves the latch in the status, the filter
        // stays installed as long as the user still wants it and the
        // controller situation is sane; a granted quit keeps it off.
        lat_filter = ns.enable && i_item.ctrl_present &&
                     !i_item.extra_ctrl;
        if (ns.status == ST_LATCH && !quit_ok) begin
            filter   = lat_filter;
            dispatch = 1'b0;
        end
    end

    assign o_state                 = ns;
    assign o_result.status         = ns.status;
    assign o_result.reason         = ns.reason;
    assign o_result.fault_code     = ns.fault;
    assign o_result.fault_latched  = ns.latch;
    assign o_result.enabled        = ns.enable;
    assign o_result.drive_filter   = filter;
    assign o_result.drive_dispatch = dispatch;
    assign o_result.drive_cleanup  = cleanup;
    assign o_result.quit_clear     = quit_ok;

endmodule

// ===== hdl/safety_interlock_enable_sequencer_unit.sv =====
// Top level of the safety interlock enable sequencer: input register, step logic, result register.
`timescale 1ns / 1ps

// Usage
// Each input transaction carries one user command (none, enable, disable, retry,
// quit), a snapshot of the gate flags and an observed fault. For every input
// transaction the block returns exactly one result transaction with the status,
// the inactive reason, the held fault code, the latch and enable flags and the
// filter, dispatch, cleanup and quit-allowed requests.
// Both channels use valid and stall; a transaction moves on an edge where valid
// is high and stall is low.
// A transaction accepted at an edge sits in the input register and passes
// through the step logic into the result register, where o_valid rises; a
// stalled receiver can hold it in the input register. One short pass of logic
// does the work, so a transaction fits every cycle while the receiver does not stall.
// When the receiver stalls, the result register holds its transaction and the
// input register can still take one more; o_stall rises only when both are
// full and the receiver stalls.
// Reset (synchronous, active low) empties both registers and returns the
// sequencer to disabled with no latch, no fault and no pending disable or quit.
// Unknown command codes act as none; unknown fault codes count as device
// uncertain.
module safety_interlock_enable_sequencer_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Command channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [2:0] i_command,
    input  logic       i_access_ok,
    input  logic       i_extra_ctrl,
    input  logic       i_ctrl_present,
    input  logic       i_session_available,
    input  logic       i_target_foreground,
    input  logic       i_filter_live,
    input  logic       i_controls_neutral,
    input  logic [2:0] i_observed_fault,
    input  logic       i_device_reports_latched,
    input  logic       i_cleanup_done,
    input  logic       i_recovery_check_ok,
    // Result channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_status,
    output logic [3:0] o_idle_cause,
    output logic [2:0] o_fault_code,
    output logic       o_fault_latched,
    output logic       o_enabled,
    output logic       o_drive_filter,
    output logic       o_drive_dispatch,
    output logic       o_drive_cleanup,
    output logic       o_quit_clear
);
    import sies_pkg::*;

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_result;
    t_state  r_state;

    t_state  n_state;
    t_result n_result;
    t_item   n_item;
    logic    out_free;
    logic    advance;
    logic    in_accept;

    // The result register can take a new transaction when it is empty or
    // when its current one leaves on this edge.
    assign out_free  = !r_out_valid || !i_stall;
    assign advance   = r_in_valid && out_free;
    assign o_stall   = r_in_valid && !out_free;
    assign in_accept = i_valid && !o_stall;

    assign n_item.command                = i_command;
    assign n_item.access_ok              = i_access_ok;
    assign n_item.extra_ctrl             = i_extra_ctrl;
    assign n_item.ctrl_present           = i_ctrl_present;
    assign n_item.session_available      = i_session_available;
    assign n_item.target_foreground      = i_target_foreground;
    assign n_item.filter_live            = i_filter_live;
    assign n_item.controls_neutral       = i_controls_neutral;
    assign n_item.observed_fault         = i_observed_fault;
    assign n_item.device_reports_latched = i_device_reports_latched;
    assign n_item.cleanup_done           = i_cleanup_done;
    assign n_item.recovery_check_ok      = i_recovery_check_ok;

    // The state only moves when the registered command passes into the
    // result register, so stalls never repeat or skip an update.
    sies_step u_step (
        .i_item   (r_item),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid           <= 1'b0;
            r_out_valid          <= 1'b0;
            r_state.status       <= ST_DISABLED;
            r_state.reason       <= RSN_NONE;
            r_state.enable       <= 1'b0;
            r_state.latch        <= 1'b0;
            r_state.fault        <= FAULT_NONE;
            r_state.disable_wait <= 1'b0;
            r_state.quit_pending <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item <= n_item;
        end
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_result.status;
    assign o_idle_cause     = r_result.reason;
    assign o_fault_code     = r_result.fault_code;
    assign o_fault_latched  = r_result.fault_latched;
    assign o_enabled        = r_result.enabled;
    assign o_drive_filter   = r_result.drive_filter;
    assign o_drive_dispatch = r_result.drive_dispatch;
    assign o_drive_cleanup  = r_result.drive_cleanup;
    assign o_quit_clear     = r_result.quit_clear;

endmodule

// ===== hdl/sies_checker.sv =====
// Port-level assertions for the sequencer top level and the bind that attaches them.
`timescale 1ns / 1ps

module sies_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [1:0] o_status,
    input logic [3:0] o_idle_cause,
    input logic [2:0] o_fault_code,
    input logic       o_fault_latched,
    input logic       o_enabled,
    input logic       o_drive_filter,
    input logic       o_drive_dispatch,
    input logic       o_drive_cleanup,
    input logic       o_quit_clear
);
    import sies_pkg::*;

    // A result is never shown in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // The block only stalls its input while a result waits on a stalled receiver.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled with room in the result register");

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_status) &&
            $stable(o_fault_code) && $stable(o_drive_cleanup) && $stable(o_enabled)))
        else $error("stalled result changed");

    // A held latch always shows as latch status with a real fault code.
    a_latch_view: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_fault_latched) |->
            (o_status == ST_LATCH && o_idle_cause == RSN_LATCH &&
             o_fault_code != FAULT_NONE))
        else $error("latch held without latch status or fault code");

    // Dispatch only while active; a granted quit cleans up with the filter off.
    a_dispatch_quit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((!o_drive_dispatch || (o_status == ST_ACTIVE && o_drive_filter &&
            !o_drive_cleanup)) && (!o_quit_clear || (o_drive_cleanup && !o_drive_filter))))
        else $error("dispatch or quit request inconsistent with status");

endmodule

bind safety_interlock_enable_sequencer_unit sies_checker u_sies_checker (.*);
